### hdl/co2sla_pkg.sv
// ----------------------------------------------------------------------------
// CO2 sensor link alarm package
// Shared types, constants and byte tables for the sensor link alarm block.
// ----------------------------------------------------------------------------
`default_nettype none

package co2sla_pkg;

  // Sensor frame length and the stored part of it (the last byte is checked on arrival).
  localparam int unsigned FRAME_BYTES  = 9;
  localparam int unsigned STORE_BYTES  = FRAME_BYTES - 1;
  localparam int unsigned STORE_IDX_W  = $clog2(STORE_BYTES);
  localparam int unsigned RX_COUNT_W   = 4;

  // Screen frame is four bytes, then an optional read request.
  localparam int unsigned SCREEN_BYTES = 4;
  localparam int unsigned SEQ_BYTES    = SCREEN_BYTES + FRAME_BYTES;
  localparam int unsigned SEQ_IDX_W    = $clog2(SEQ_BYTES);

  // Default depth of the command queue between front and back.
  localparam int unsigned CMD_DEPTH    = 4;

  // Register reset values.
  localparam logic [15:0] RST_LEVEL_RED  = 16'd2500;
  localparam logic [15:0] RST_LEVEL_HIGH = 16'd1500;
  localparam logic [15:0] RST_LEVEL_MID  = 16'd1200;
  localparam logic [15:0] RST_LEVEL_LOW  = 16'd800;
  localparam logic [7:0]  RST_PERIOD     = 8'd10;

  // Frame bytes.
  localparam logic [7:0] BYTE_START    = 8'hFF;
  localparam logic [7:0] BYTE_SENSOR   = 8'h01;
  localparam logic [7:0] BYTE_READ_CMD = 8'h86;
  localparam logic [7:0] REQ_CHECKSUM  = 8'(9'h100 - 9'(BYTE_SENSOR + BYTE_READ_CMD));
  localparam logic [7:0] TEMP_OFFSET   = 8'd40;
  // High byte of the screen word (0x200 | colour) << 4.
  localparam logic [7:0] SCREEN_HI     = 8'h20;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LEVEL_RED  = 3'd0,
    REG_LEVEL_HIGH = 3'd1,
    REG_LEVEL_MID  = 3'd2,
    REG_LEVEL_LOW  = 3'd3,
    REG_PERIOD     = 3'd4
  } cfg_reg_e;

  // Input modes.
  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_BYTE = 1'b1
  } mode_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_SENSOR_TX = 2'd0,
    KIND_SCREEN_TX = 2'd1,
    KIND_GOOD      = 2'd2,
    KIND_BAD       = 2'd3
  } kind_e;

  // Commands handed from the front to the back.
  typedef enum logic [1:0] {
    OP_SCREEN = 2'd0,
    OP_GOOD   = 2'd1,
    OP_BAD    = 2'd2
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [2:0]         colour;
    logic               req;
    logic [15:0]        ppm;
    logic signed [7:0]  temp;
  } cmd_t;

  // Byte of the read request frame at a given position.
  function automatic logic [7:0] req_byte(input logic [SEQ_IDX_W-1:0] pos);
    logic [7:0] b;
    case (pos)
      SEQ_IDX_W'(0):               b = BYTE_START;
      SEQ_IDX_W'(1):               b = BYTE_SENSOR;
      SEQ_IDX_W'(2):               b = BYTE_READ_CMD;
      SEQ_IDX_W'(FRAME_BYTES - 1): b = REQ_CHECKSUM;
      default:                     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### hdl/co2sla_if.sv
// ----------------------------------------------------------------------------
// CO2 sensor link alarm channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface co2sla_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, mode, rx_byte, input ready);
  modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface co2sla_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        tx_byte;
  logic [15:0]       ppm;
  logic signed [7:0] temperature;
  logic              last;

  modport source (output valid, kind, tx_byte, ppm, temperature, last, input ready);
  modport sink   (input valid, kind, tx_byte, ppm, temperature, last, output ready);
endinterface

interface co2sla_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/co2_sensor_link_alarm.sv
// A result word is offered once its command has passed through the command queue and
// been loaded into the back end, and it leaves when the result channel is ready.
// Throughput: one result word per cycle while the result channel is ready, set by the single
// result port of the back end; a tick yields 4 words, or 13 with a read request, a frame 1.
// Input words are taken every cycle while the command queue has room.
// Reset (rst_ni low, asynchronous) clears counters, level and queue; registers take defaults.
// ----------------------------------------------------------------------------
// CO2 sensor link alarm top level
// Front end, command queue and back end for the sensor link and alarm screen.
// ----------------------------------------------------------------------------
`default_nettype none

module co2_sensor_link_alarm #(
  parameter int unsigned CMD_DEPTH = co2sla_pkg::CMD_DEPTH
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  co2sla_in_if.sink     in_i,
  co2sla_cfg_if.sink    cfg_i,
  co2sla_out_if.source  out_o
);
  import co2sla_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  co2sla_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  co2sla_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (front_cmd),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_data_o  (back_cmd),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready)
  );

  co2sla_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

### hdl/co2sla_front.sv
// ----------------------------------------------------------------------------
// CO2 sensor link alarm front end
// Holds registers and link state, turns each tick and each completed frame into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module co2sla_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  co2sla_in_if.sink           in_i,
  co2sla_cfg_if.sink          cfg_i,
  output co2sla_pkg::cmd_t    cmd_o,
  output logic                cmd_valid_o,
  input  wire                 cmd_ready_i
);
  import co2sla_pkg::*;

  logic [15:0] level_red_q, level_high_q, level_mid_q, level_low_q;
  logic [7:0]  period_q;
  logic [7:0]  tick_q, tick_d;
  logic [15:0] co2_q, co2_d;
  logic [RX_COUNT_W-1:0] rx_count_q, rx_count_d;
  logic [7:0]  frame_q [STORE_BYTES];

  logic        accept;
  logic        frame_end;
  logic [7:0]  sum;
  logic        sum_ok;
  logic [7:0]  tick_inc;
  logic        odd;
  logic [2:0]  colour;

  // Register writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_red_q  <= RST_LEVEL_RED;
      level_high_q <= RST_LEVEL_HIGH;
      level_mid_q  <= RST_LEVEL_MID;
      level_low_q  <= RST_LEVEL_LOW;
      period_q     <= RST_PERIOD;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_LEVEL_RED:  level_red_q  <= cfg_i.data;
        REG_LEVEL_HIGH: level_high_q <= cfg_i.data;
        REG_LEVEL_MID:  level_mid_q  <= cfg_i.data;
        REG_LEVEL_LOW:  level_low_q  <= cfg_i.data;
        REG_PERIOD:     period_q     <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // Every input word may produce a command, so wait for queue space.
  assign in_i.ready  = cmd_ready_i;
  assign accept      = in_i.valid & cmd_ready_i;
  assign frame_end   = (rx_count_q == RX_COUNT_W'(FRAME_BYTES - 1));

  // Checksum: stored bytes 1..7 plus the arriving byte sum to zero.
  always_comb begin
    sum = in_i.rx_byte;
    for (int i = 1; i < STORE_BYTES; i++) begin
      sum = sum + frame_q[i];
    end
  end
  assign sum_ok = (sum == 8'h00);

  // Alarm colour from the last level, alternating with tick parity above the low level.
  assign odd = tick_q[0];
  always_comb begin
    if (co2_q > level_red_q) begin
      colour = odd ? 3'd0 : 3'd7;
    end else if (co2_q > level_high_q) begin
      colour = odd ? 3'd3 : 3'd4;
    end else if (co2_q > level_mid_q) begin
      colour = odd ? 3'd0 : 3'd3;
    end else if (co2_q > level_low_q) begin
      colour = odd ? 3'd1 : 3'd2;
    end else begin
      colour = 3'd0;
    end
  end

  assign tick_inc = tick_q + 8'd1;

  // Command build and state update.
  always_comb begin
    tick_d      = tick_q;
    co2_d       = co2_q;
    rx_count_d  = rx_count_q;
    cmd_valid_o = 1'b0;
    cmd_o.op     = OP_SCREEN;
    cmd_o.colour = colour;
    cmd_o.req    = 1'b0;
    cmd_o.ppm    = '0;
    cmd_o.temp   = '0;
    if (mode_e'(in_i.mode) == MODE_TICK) begin
      cmd_valid_o = in_i.valid;
      if (tick_inc == period_q) begin
        cmd_o.req = 1'b1;
        tick_d    = 8'd0;
      end else begin
        tick_d = tick_inc;
      end
    end else if (frame_end) begin
      cmd_valid_o = in_i.valid;
      rx_count_d  = '0;
      if (sum_ok) begin
        cmd_o.op   = OP_GOOD;
        cmd_o.ppm  = {frame_q[2], frame_q[3]};
        cmd_o.temp = signed'(frame_q[4] - TEMP_OFFSET);
        co2_d      = {frame_q[2], frame_q[3]};
      end else begin
        cmd_o.op = OP_BAD;
      end
    end else begin
      rx_count_d = rx_count_q + RX_COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      co2_q      <= '0;
      rx_count_q <= '0;
    end else if (accept) begin
      tick_q     <= tick_d;
      co2_q      <= co2_d;
      rx_count_q <= rx_count_d;
    end
  end

  // Frame byte store; the final byte is never stored.
  always_ff @(posedge clk_i) begin
    if (accept && mode_e'(in_i.mode) == MODE_BYTE && !frame_end) begin
      frame_q[rx_count_q[STORE_IDX_W-1:0]] <= in_i.rx_byte;
    end
  end

endmodule

`default_nettype wire

### hdl/co2sla_fifo.sv
// ----------------------------------------------------------------------------
// CO2 sensor link alarm command queue
// Small first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module co2sla_fifo #(
  parameter int unsigned DEPTH = co2sla_pkg::CMD_DEPTH
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  co2sla_pkg::cmd_t    wr_data_i,
  input  wire                 wr_valid_i,
  output logic                wr_ready_o,
  output co2sla_pkg::cmd_t    rd_data_o,
  output logic                rd_valid_o,
  input  wire                 rd_ready_i
);
  import co2sla_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign wr_ready_o = (count_q != CntW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/co2sla_back.sv
// ----------------------------------------------------------------------------
// CO2 sensor link alarm back end
// Expands each command into its sequence of result words, one per cycle while ready.
// ----------------------------------------------------------------------------
`default_nettype none

module co2sla_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  co2sla_pkg::cmd_t    cmd_i,
  input  wire                 cmd_valid_i,
  output logic                cmd_ready_o,
  co2sla_out_if.source        out_o
);
  import co2sla_pkg::*;

  cmd_t                 cur_q;
  logic                 busy_q;
  logic [SEQ_IDX_W-1:0] idx_q;
  logic                 is_last;
  logic                 fire;
  logic [7:0]           lo;

  assign lo = {1'b0, cur_q.colour, 4'b0000};

  // Result word for the current command and position.
  always_comb begin
    out_o.kind        = KIND_SCREEN_TX;
    out_o.tx_byte     = 8'h00;
    out_o.ppm         = '0;
    out_o.temperature = '0;
    is_last           = 1'b1;
    case (cur_q.op)
      OP_SCREEN: begin
        if (idx_q < SEQ_IDX_W'(SCREEN_BYTES)) begin
          out_o.kind = KIND_SCREEN_TX;
          case (idx_q)
            SEQ_IDX_W'(0): out_o.tx_byte = BYTE_START;
            SEQ_IDX_W'(1): out_o.tx_byte = SCREEN_HI;
            SEQ_IDX_W'(2): out_o.tx_byte = SCREEN_HI ^ lo;
            default:       out_o.tx_byte = lo;
          endcase
          is_last = !cur_q.req && (idx_q == SEQ_IDX_W'(SCREEN_BYTES - 1));
        end else begin
          out_o.kind    = KIND_SENSOR_TX;
          out_o.tx_byte = req_byte(idx_q - SEQ_IDX_W'(SCREEN_BYTES));
          is_last       = (idx_q == SEQ_IDX_W'(SEQ_BYTES - 1));
        end
      end
      OP_GOOD: begin
        out_o.kind        = KIND_GOOD;
        out_o.ppm         = cur_q.ppm;
        out_o.temperature = cur_q.temp;
      end
      default: begin
        out_o.kind = KIND_BAD;
      end
    endcase
  end

  assign out_o.valid = busy_q;
  assign out_o.last  = is_last;
  assign fire        = busy_q & out_o.ready;
  // Take the next command when empty or as the final word leaves.
  assign cmd_ready_o = !busy_q || (fire && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (cmd_ready_o) begin
      busy_q <= cmd_valid_i;
      idx_q  <= '0;
    end else if (fire) begin
      idx_q <= idx_q + SEQ_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ready_o && cmd_valid_i) begin
      cur_q <= cmd_i;
    end
  end

endmodule

`default_nettype wire

### tb/co2_sensor_link_alarm_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CO2 sensor link alarm testbench
// Drives ticks and sensor bytes through the input channel and predicts every
// result word: screen frames, read requests and frame verdicts. Each word
// taken from the result channel is checked against the oldest prediction.
// The run walks a short table of directed items and then random traffic
// built mostly from well-formed sensor frames. Phases change the thresholds
// and the request period, and also vary the idle cycles on both channels.
// ----------------------------------------------------------------------------

module co2_sensor_link_alarm_tb;
  import co2sla_pkg::*;

  // How a directed row gets its expected words.
  typedef enum {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_FRAME_ERR,
    ROW_SCREEN_DARK
  } row_check_e;

  typedef enum {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_e;

  typedef struct {
    mode_e      mode;
    logic [7:0] data;
    row_check_e check;
  } stim_row_t;

  typedef struct {
    kind_e             kind;
    logic [7:0]        tx;
    logic [15:0]       ppm;
    logic signed [7:0] temp;
    logic              last;
  } link_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  co2sla_in_if  in_ch ();
  co2sla_cfg_if cfg_ch ();
  co2sla_out_if out_ch ();

  co2_sensor_link_alarm dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .cfg_i (cfg_ch),
    .out_o (out_ch)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the block: registers, tick counter, level and frame gathering.
  logic [15:0] m_level [4];
  logic [7:0]  m_period;
  logic [7:0]  m_ticks;
  logic [15:0] m_co2;
  logic [7:0]  m_frame [FRAME_BYTES];
  int unsigned m_fill;

  link_word_t  step_out [SEQ_BYTES];
  int          step_count;
  link_word_t  awaited_words [$];
  link_word_t  head_word;
  int          fail_count = 0;
  int          items_sent = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;

  stim_row_t   directed_rows [23];

  // Two's complement of the sum of bytes 1 to 7.
  function automatic logic [7:0] frame_checksum(input logic [7:0] f [FRAME_BYTES]);
    logic [7:0] sum;
    sum = 8'd0;
    for (int i = 1; i < 8; i++) sum = sum + f[i];
    return 8'd0 - sum;
  endfunction

  // Advances the shadow state by one input word and fills step_out with the
  // result words it causes. Returns how many there are.
  function automatic int predict_step(mode_e mode, logic [7:0] data);
    int          n;
    logic [2:0]  colour;
    logic [15:0] screen;
    logic [7:0]  req [FRAME_BYTES];
    n = 0;
    if (mode == MODE_TICK) begin
      // Colour pair by level, member of the pair by tick parity.
      if (m_co2 > m_level[REG_LEVEL_RED])       colour = m_ticks[0] ? 3'd0 : 3'd7;
      else if (m_co2 > m_level[REG_LEVEL_HIGH]) colour = m_ticks[0] ? 3'd3 : 3'd4;
      else if (m_co2 > m_level[REG_LEVEL_MID])  colour = m_ticks[0] ? 3'd0 : 3'd3;
      else if (m_co2 > m_level[REG_LEVEL_LOW])  colour = m_ticks[0] ? 3'd1 : 3'd2;
      else                                      colour = 3'd0;
      screen = {8'h02, 5'd0, colour} << 4;
      step_out[0] = '{KIND_SCREEN_TX, 8'hFF, 16'd0, 8'sd0, 1'b0};
      step_out[1] = '{KIND_SCREEN_TX, screen[15:8], 16'd0, 8'sd0, 1'b0};
      step_out[2] = '{KIND_SCREEN_TX, screen[15:8] ^ screen[7:0], 16'd0, 8'sd0, 1'b0};
      step_out[3] = '{KIND_SCREEN_TX, screen[7:0], 16'd0, 8'sd0, 1'b0};
      n = 4;
      // The counter wraps through 255 when the period is below it.
      m_ticks = m_ticks + 8'd1;
      if (m_ticks == m_period) begin
        m_ticks = 8'd0;
        req = '{BYTE_START, BYTE_SENSOR, BYTE_READ_CMD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        req[8] = frame_checksum(req);
        for (int i = 0; i < FRAME_BYTES; i++) begin
          step_out[n] = '{KIND_SENSOR_TX, req[i], 16'd0, 8'sd0, 1'b0};
          n++;
        end
      end
    end else begin
      m_frame[m_fill] = data;
      m_fill++;
      if (m_fill == FRAME_BYTES) begin
        m_fill = 0;
        if (m_frame[8] == frame_checksum(m_frame)) begin
          m_co2 = {m_frame[2], m_frame[3]};
          step_out[0] = '{KIND_GOOD, 8'd0, m_co2, $signed(8'(m_frame[4] - 8'd40)), 1'b0};
        end else begin
          step_out[0] = '{KIND_BAD, 8'd0, 16'd0, 8'sd0, 1'b0};
        end
        n = 1;
      end
    end
    if (n > 0) step_out[n-1].last = 1'b1;
    return n;
  endfunction

  // Offers one input word, waits for it to be taken, then queues its results.
  task automatic send_item(mode_e mode, logic [7:0] data, row_check_e check);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= mode;
    in_ch.rx_byte <= data;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    items_sent++;
    step_count = predict_step(mode, data);
    case (check)
      ROW_PREDICT: begin
        for (int i = 0; i < step_count; i++) awaited_words.push_back(step_out[i]);
      end
      ROW_SILENT: begin
      end
      ROW_FRAME_ERR: begin
        awaited_words.push_back('{KIND_BAD, 8'd0, 16'd0, 8'sd0, 1'b1});
      end
      ROW_SCREEN_DARK: begin
        awaited_words.push_back('{KIND_SCREEN_TX, 8'hFF, 16'd0, 8'sd0, 1'b0});
        awaited_words.push_back('{KIND_SCREEN_TX, 8'h20, 16'd0, 8'sd0, 1'b0});
        awaited_words.push_back('{KIND_SCREEN_TX, 8'h20, 16'd0, 8'sd0, 1'b0});
        awaited_words.push_back('{KIND_SCREEN_TX, 8'h00, 16'd0, 8'sd0, 1'b1});
      end
    endcase
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_PERIOD: m_period = value[7:0];
      default:    m_level[idx] = value;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_levels(logic [15:0] red, logic [15:0] high, logic [15:0] mid,
                              logic [15:0] low);
    write_reg(REG_LEVEL_RED, red);
    write_reg(REG_LEVEL_HIGH, high);
    write_reg(REG_LEVEL_MID, mid);
    write_reg(REG_LEVEL_LOW, low);
  endtask

  // Lowers valid and waits until every predicted word is out and the block is quiet.
  task automatic wait_quiet();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_idle(idle_e m);
    case (m)
      IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_gap_pct = 50; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 50; end
      IDLE_BOTH:     begin send_gap_pct = 31; recv_stall_pct = 31; end
    endcase
  endtask

  // Levels near the thresholds are the interesting ones.
  function automatic logic [15:0] pick_ppm();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return 16'd0;
      2:       return 16'hFFFF;
      default: return m_level[$urandom_range(0, 3)] - 16'd1 + 16'($urandom_range(0, 2));
    endcase
  endfunction

  // One random unit: a tick, a good or corrupted frame, or a few stray bytes.
  task automatic send_random_unit(int tick_pct);
    int         r;
    logic [7:0] fr [FRAME_BYTES];
    logic [15:0] ppm;
    r = $urandom_range(0, 99);
    if (r < tick_pct) begin
      send_item(MODE_TICK, 8'($urandom), ROW_PREDICT);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        repeat ($urandom_range(1, 8)) send_item(MODE_BYTE, 8'($urandom), ROW_PREDICT);
      end else begin
        // Finish any partial frame so that the new one lines up.
        while (m_fill != 0) send_item(MODE_BYTE, 8'($urandom), ROW_PREDICT);
        ppm = pick_ppm();
        fr[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : BYTE_START;
        fr[1] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : BYTE_READ_CMD;
        fr[2] = ppm[15:8];
        fr[3] = ppm[7:0];
        for (int i = 4; i < 8; i++) fr[i] = 8'($urandom);
        fr[8] = frame_checksum(fr);
        if (r >= 82) fr[8] = fr[8] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < FRAME_BYTES; i++) begin
          if ($urandom_range(0, 9) == 0) send_item(MODE_TICK, 8'($urandom), ROW_PREDICT);
          send_item(MODE_BYTE, fr[i], ROW_PREDICT);
        end
      end
    end
  endtask

  task automatic run_random(int n_items, int tick_pct);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_unit(tick_pct);
  endtask

  // Receiver side: ready changes at the falling edge.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic bit field_ok(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Result checker: every accepted word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got kind %0d tx %0h", $time,
                 out_ch.kind, out_ch.tx_byte);
        fail_count++;
      end else begin
        head_word = awaited_words.pop_front();
        if (!(field_ok("kind", head_word.kind, out_ch.kind) &
              field_ok("tx_byte", head_word.tx, out_ch.tx_byte) &
              field_ok("ppm", head_word.ppm, out_ch.ppm) &
              field_ok("temperature", 8'(head_word.temp), 8'(out_ch.temperature)) &
              field_ok("last", head_word.last, out_ch.last)))
          fail_count++;
      end
    end
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [7:0] low_period;
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_TICK;
    in_ch.rx_byte  = 8'd0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_LEVEL_RED;
    cfg_ch.data    = 16'd0;
    out_ch.ready   = 1'b0;
    rst_ni         = 1'b0;

    m_level[REG_LEVEL_RED]  = RST_LEVEL_RED;
    m_level[REG_LEVEL_HIGH] = RST_LEVEL_HIGH;
    m_level[REG_LEVEL_MID]  = RST_LEVEL_MID;
    m_level[REG_LEVEL_LOW]  = RST_LEVEL_LOW;
    m_period = RST_PERIOD;
    m_ticks  = 8'd0;
    m_co2    = 16'd0;
    m_fill   = 0;
    foreach (m_frame[i]) m_frame[i] = 8'd0;

    // Two dark ticks, a full-scale good frame, a corrupted frame, then ticks
    // that alternate the top alarm colours.
    directed_rows = '{
      '{MODE_TICK, 8'h00, ROW_SCREEN_DARK},
      '{MODE_TICK, 8'hFF, ROW_SCREEN_DARK},
      '{MODE_BYTE, 8'hFF, ROW_SILENT},
      '{MODE_BYTE, 8'h86, ROW_SILENT},
      '{MODE_BYTE, 8'hFF, ROW_SILENT},
      '{MODE_BYTE, 8'hFF, ROW_SILENT},
      '{MODE_BYTE, 8'h00, ROW_SILENT},
      '{MODE_BYTE, 8'h00, ROW_SILENT},
      '{MODE_BYTE, 8'h00, ROW_SILENT},
      '{MODE_BYTE, 8'h00, ROW_SILENT},
      '{MODE_BYTE, 8'h7C, ROW_PREDICT},
      '{MODE_BYTE, 8'h00, ROW_SILENT},
      '{MODE_BYTE, 8'h00, ROW_SILENT},
      '{MODE_BYTE, 8'h00, ROW_SILENT},
      '{MODE_BYTE, 8'h00, ROW_SILENT},
      '{MODE_BYTE, 8'h00, ROW_SILENT},
      '{MODE_BYTE, 8'h00, ROW_SILENT},
      '{MODE_BYTE, 8'h00, ROW_SILENT},
      '{MODE_BYTE, 8'h00, ROW_SILENT},
      '{MODE_BYTE, 8'h01, ROW_FRAME_ERR},
      '{MODE_TICK, 8'h00, ROW_PREDICT},
      '{MODE_TICK, 8'hFF, ROW_PREDICT},
      '{MODE_TICK, 8'h5A, ROW_PREDICT}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values, no idling.
    set_idle(IDLE_NONE);
    foreach (directed_rows[i])
      send_item(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].check);
    run_random(16, 40);
    wait_quiet();

    // Lowest thresholds and a request period of one tick.
    write_levels(16'd0, 16'd0, 16'd0, 16'd0);
    write_reg(REG_PERIOD, 16'd1);
    set_idle(IDLE_SENDER);
    run_random(16, 40);
    wait_quiet();

    // Highest thresholds and the longest period.
    write_levels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(REG_PERIOD, 16'd255);
    set_idle(IDLE_RECEIVER);
    run_random(16, 45);
    wait_quiet();

    // Period dropped below the running count: the counter has to wrap, which
    // takes a long run of ticks, so little random traffic follows it.
    low_period = (m_ticks > 8'd2) ? m_ticks - 8'd2 : 8'd1;
    write_reg(REG_PERIOD, {8'd0, low_period});
    write_levels(16'(3000 + $urandom_range(0, 2000)), 16'($urandom_range(1500, 2999)),
                 16'($urandom_range(1000, 1499)), 16'($urandom_range(1, 999)));
    set_idle(IDLE_BOTH);
    if (m_ticks > m_period) begin
      do send_item(MODE_TICK, 8'($urandom), ROW_PREDICT); while (step_count != SEQ_BYTES);
    end
    run_random(8, 40);
    wait_quiet();

    // Unordered random thresholds and a short period.
    write_levels(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    write_reg(REG_PERIOD, 16'($urandom_range(1, 6)));
    set_idle(IDLE_NONE);
    run_random(16, 40);
    wait_quiet();

    // Default thresholds again with a period of two.
    write_levels(RST_LEVEL_RED, RST_LEVEL_HIGH, RST_LEVEL_MID, RST_LEVEL_LOW);
    write_reg(REG_PERIOD, 16'd2);
    set_idle(IDLE_BOTH);
    run_random(16, 40);
    wait_quiet();

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
hdl/co2sla_pkg.sv
hdl/co2sla_if.sv
hdl/co2sla_front.sv
hdl/co2sla_fifo.sv
hdl/co2sla_back.sv
hdl/co2_sensor_link_alarm.sv
tb/co2_sensor_link_alarm_tb.sv
